// ----- design/blc_pkg.sv -----
// Shared types, constants and helpers of the likelihood combiner.
package blc_pkg;

   localparam int MAX_DETECTORS  = 8;
   localparam int MAX_HYPOTHESES = 4;
   localparam int FRAC_BITS      = 16;
   localparam int NUM_PRIORS     = 4;
   localparam int HYP_LIMIT      = (MAX_HYPOTHESES < NUM_PRIORS) ? MAX_HYPOTHESES : NUM_PRIORS;

   // Field widths
   localparam int OP_W       = 2;
   localparam int DET_W      = 3;
   localparam int HYP_W      = 2;
   localparam int VAL_W      = FRAC_BITS + 1;
   localparam int ND_W       = 4;
   localparam int NP_W       = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam int TBL_DEPTH  = MAX_DETECTORS * MAX_HYPOTHESES;
   localparam int TBL_AW     = $clog2(TBL_DEPTH);
   localparam int PROD_W     = 2 * VAL_W;
   localparam int WGT_W      = 2 * VAL_W - 1;
   localparam int SUM_W      = WGT_W + $clog2(NUM_PRIORS);
   localparam int DIV_CNT_W  = $clog2(FRAC_BITS + 1);

   localparam logic [VAL_W-1:0] ONE_FX = VAL_W'(1) << FRAC_BITS;

   typedef enum logic [OP_W-1:0] {
      OP_STORE   = 2'd0,
      OP_COMBINE = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NUM_DET  = 3'd0,
      REG_NUM_PART = 3'd1,
      REG_PRIOR_0  = 3'd2,
      REG_PRIOR_1  = 3'd3,
      REG_PRIOR_2  = 3'd4,
      REG_PRIOR_3  = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PSTART,
      S_RD,
      S_MUL,
      S_WGT,
      S_EMIT,
      S_DIV,
      S_OUT
   } state_type;

   typedef struct packed {
      logic              en;
      logic [TBL_AW-1:0] addr;
      logic [VAL_W-1:0]  data;
   } tbl_wr_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] num;
      logic [SUM_W-1:0] den;
   } div_req_type;

   function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
      return (v > ONE_FX) ? ONE_FX : v;
   endfunction

   function automatic logic [TBL_AW-1:0] tbl_addr(input logic [DET_W-1:0] d,
                                                  input logic [HYP_W-1:0] h);
      return TBL_AW'(int'(d) * MAX_HYPOTHESES + int'(h));
   endfunction

endpackage

// ----- design/blc_table.sv -----
// Likelihood table: synchronous memory with per-entry valid bits; invalid entries read as zero.
module blc_table (
   input  logic                       clock,
   input  logic                       reset,
   input  blc_pkg::tbl_wr_type        wr,
   input  logic                       clr,
   input  logic                       rd_en,
   input  logic [blc_pkg::TBL_AW-1:0] rd_addr,
   output logic [blc_pkg::VAL_W-1:0]  rd_data
);
   import blc_pkg::*;

   logic [VAL_W-1:0]     mem [TBL_DEPTH];
   logic [VAL_W-1:0]     mem_q_ff;
   logic [TBL_DEPTH-1:0] valid_ff, valid_in;
   logic                 hit_ff, hit_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (clr) begin
         valid_in = '0;
      end else if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
      hit_in = rd_en ? valid_ff[rd_addr] : hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   // never-written or cleared entries read as zero
   assign rd_data = hit_ff ? mem_q_ff : '0;

endmodule

// ----- design/blc_div.sv -----
// Restoring divider, one quotient bit a cycle, giving floor(num * 1.0 / den).
module blc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  blc_pkg::div_req_type      req,
   output logic                      done,
   output logic [blc_pkg::VAL_W-1:0] quot
);
   import blc_pkg::*;

   logic [SUM_W-1:0]     rem_ff, den_ff;
   logic [VAL_W-1:0]     quot_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [SUM_W:0]       rem_sh;
   logic                 step_ge, first_ge;
   logic [SUM_W-1:0]     rem_nx;

   always_comb begin
      rem_sh   = {rem_ff, 1'b0};
      step_ge  = rem_sh >= {1'b0, den_ff};
      rem_nx   = step_ge ? SUM_W'(rem_sh - {1'b0, den_ff}) : SUM_W'(rem_sh);
      first_ge = req.num >= req.den;
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         den_ff  <= req.den;
         rem_ff  <= first_ge ? req.num - req.den : req.num;
         quot_ff <= VAL_W'(first_ge);
      end else if (busy_ff) begin
         rem_ff  <= rem_nx;
         quot_ff <= {quot_ff[VAL_W-2:0], step_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(FRAC_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ----- design/bayes_likelihood_combiner.sv -----
// Store and clear are taken in the idle state; a combine is accepted, then the products
// over P hypotheses and D detectors are formed, then each hypothesis is divided by the
// restoring divider and emitted (the divide is skipped when the weighted sum is zero).
// The table memory has one read port, read once per detector and hypothesis.
// A waiting result does not block the next item until that item's own results.
// Reset: configuration to defaults, table reads as all zero at once, no clearing pass.
module bayes_likelihood_combiner (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // detector_index[2:0], hypothesis_index[4:3], likelihood[21:5], zero fill
   input  logic [blc_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [blc_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // result_hypothesis[1:0], posterior[18:2], zero fill
   output logic [blc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // zero_sum[0]
   output logic [0:0]                     rsp_tuser,
   output logic                           rsp_tlast,
   input  logic                           csr_wen,
   input  logic [blc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [blc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import blc_pkg::*;

   state_type        state_ff, state_in;

   logic [ND_W-1:0]  num_det_ff;
   logic [NP_W-1:0]  num_part_ff;
   logic [VAL_W-1:0] prior_ff [NUM_PRIORS];

   logic [ND_W-1:0]  nd_ff, nd_sat;
   logic [NP_W-1:0]  np_ff, np_sat;
   logic [HYP_W-1:0] p_ff;
   logic [DET_W-1:0] d_ff;

   logic [VAL_W-1:0] acc_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [VAL_W-1:0] prod_ff [HYP_LIMIT];
   logic [WGT_W-1:0] wgt_ff  [HYP_LIMIT];
   logic [VAL_W-1:0] post_ff;

   logic             rsp_valid_ff;
   logic [HYP_W-1:0] rsp_hyp_ff;
   logic [VAL_W-1:0] rsp_post_ff;
   logic             rsp_zero_ff, rsp_last_ff;

   logic [DET_W-1:0] req_det;
   logic [HYP_W-1:0] req_hyp;
   logic [VAL_W-1:0] req_lik;
   logic             req_fire;
   op_type           req_op;

   tbl_wr_type       tbl_wr;
   logic             tbl_clr, rd_en;
   logic [TBL_AW-1:0] rd_addr;
   logic [VAL_W-1:0] rd_data;
   div_req_type      div_req;
   logic             div_done;
   logic [VAL_W-1:0] div_quot;

   logic [PROD_W-1:0] mul_full, wgt_full;
   logic              sum_zero, last_hyp, last_det, out_free, out_load;

   assign req_det  = req_tdata[DET_W-1:0];
   assign req_hyp  = req_tdata[DET_W+HYP_W-1:DET_W];
   assign req_lik  = req_tdata[DET_W+HYP_W+VAL_W-1:DET_W+HYP_W];
   assign req_op   = op_type'(req_tuser);
   assign req_fire = req_tvalid && req_tready;

   assign nd_sat   = (num_det_ff > ND_W'(MAX_DETECTORS)) ? ND_W'(MAX_DETECTORS) : num_det_ff;
   assign np_sat   = (num_part_ff > NP_W'(HYP_LIMIT)) ? NP_W'(HYP_LIMIT) : num_part_ff;
   assign sum_zero = (sum_ff == '0);
   assign last_hyp = (NP_W'(p_ff) + NP_W'(1)) == np_ff;
   assign last_det = (ND_W'(d_ff) + ND_W'(1)) == nd_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign mul_full = acc_ff * rd_data;
   assign wgt_full = sat_one(prior_ff[p_ff]) * acc_ff;

   blc_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .clr     (tbl_clr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   blc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_op == OP_COMBINE && np_sat != '0) begin
               state_in = S_PSTART;
            end
         end
         S_PSTART: state_in = (nd_ff == '0) ? S_WGT : S_RD;
         S_RD:     state_in = S_MUL;
         S_MUL:    state_in = last_det ? S_WGT : S_RD;
         S_WGT:    state_in = last_hyp ? S_EMIT : S_PSTART;
         S_EMIT:   state_in = sum_zero ? S_OUT : S_DIV;
         S_DIV:    state_in = div_done ? S_OUT : S_DIV;
         S_OUT: begin
            if (out_free) begin
               state_in = last_hyp ? S_IDLE : S_EMIT;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready   = 1'b0;
      tbl_wr.en    = 1'b0;
      tbl_wr.addr  = tbl_addr(req_det, req_hyp);
      tbl_wr.data  = sat_one(req_lik);
      tbl_clr      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = tbl_addr(d_ff, p_ff);
      div_req.start = 1'b0;
      div_req.num  = SUM_W'(wgt_ff[p_ff]);
      div_req.den  = sum_ff;
      out_load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_op)
                  OP_STORE: begin
                     tbl_wr.en = (int'(req_det) < MAX_DETECTORS) &&
                                 (int'(req_hyp) < MAX_HYPOTHESES);
                  end
                  OP_CLEAR: tbl_clr = 1'b1;
                  default:  ;
               endcase
            end
         end
         S_RD:    rd_en = 1'b1;
         S_EMIT:  div_req.start = !sum_zero;
         S_OUT:   out_load = out_free;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         p_ff     <= '0;
         d_ff     <= '0;
         nd_ff    <= '0;
         np_ff    <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_IDLE: begin
               if (req_fire && req_op == OP_COMBINE) begin
                  p_ff  <= '0;
                  nd_ff <= nd_sat;
                  np_ff <= np_sat;
               end
            end
            S_PSTART: d_ff <= '0;
            S_MUL:    d_ff <= d_ff + 1'b1;
            S_WGT:    p_ff <= last_hyp ? '0 : p_ff + 1'b1;
            S_OUT: begin
               if (out_free) begin
                  p_ff <= p_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_op == OP_COMBINE) begin
               sum_ff <= '0;
            end
         end
         S_PSTART: acc_ff <= ONE_FX;
         S_MUL:    acc_ff <= mul_full[FRAC_BITS+VAL_W-1:FRAC_BITS];
         S_WGT: begin
            prod_ff[p_ff] <= acc_ff;
            wgt_ff[p_ff]  <= wgt_full[WGT_W-1:0];
            sum_ff        <= sum_ff + SUM_W'(wgt_full[WGT_W-1:0]);
         end
         S_EMIT: begin
            if (sum_zero) begin
               post_ff <= prod_ff[p_ff];
            end
         end
         S_DIV: begin
            if (div_done) begin
               post_ff <= sat_one(div_quot);
            end
         end
         default: ;
      endcase
   end

   // result register: hold the item until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_hyp_ff  <= p_ff;
         rsp_post_ff <= post_ff;
         rsp_zero_ff <= sum_zero;
         rsp_last_ff <= last_hyp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_post_ff, rsp_hyp_ff});
   assign rsp_tuser  = rsp_zero_ff;
   assign rsp_tlast  = rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_det_ff  <= ND_W'(MAX_DETECTORS);
         num_part_ff <= NP_W'(4);
         for (int i = 0; i < NUM_PRIORS; i++) begin
            prior_ff[i] <= VAL_W'(16384);
         end
      end else if (csr_wen) begin
         case (csr_reg_type'(csr_index))
            REG_NUM_DET:  num_det_ff  <= csr_wdata[ND_W-1:0];
            REG_NUM_PART: num_part_ff <= csr_wdata[NP_W-1:0];
            REG_PRIOR_0:  prior_ff[0] <= csr_wdata[VAL_W-1:0];
            REG_PRIOR_1:  prior_ff[1] <= csr_wdata[VAL_W-1:0];
            REG_PRIOR_2:  prior_ff[2] <= csr_wdata[VAL_W-1:0];
            REG_PRIOR_3:  prior_ff[3] <= csr_wdata[VAL_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

// ----- tb/bayes_likelihood_combiner_test.sv -----
// Self-checking testbench for the likelihood combiner: directed rows, then random items.
module bayes_likelihood_combiner_test;
   timeunit 1ns;
   timeprecision 1ps;

   import blc_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;   // unused code, the block ignores it
   localparam int NUM_REGS           = 6;
   localparam int SETTINGS_PER_PHASE = 4;
   localparam int NUM_SETTINGS       = 3 * SETTINGS_PER_PHASE;
   localparam int ITEMS_PER_SETTING  = 22;
   localparam int HOLD_SETTING       = 9;
   localparam int HOLD_CYCLES        = 800;
   localparam int SETTLE_CYCLES      = 200;
   localparam int WATCHDOG_LIMIT     = 5000;
   localparam int MAX_REPORTS        = 10;
   localparam logic [63:0] UNITY     = 64'd1 << FRAC_BITS;

   typedef struct packed {
      logic [HYP_W-1:0] hyp;
      logic [VAL_W-1:0] post;
      logic             zs;
      logic             last;
   } posterior_type;

   typedef struct packed {
      logic [OP_W-1:0]                 op;
      logic [DET_W-1:0]                det;
      logic [HYP_W-1:0]                hyp;
      logic [VAL_W-1:0]                lik;
      logic                            known;
      logic [HYP_LIMIT-1:0][VAL_W-1:0] post;   // hypothesis 0 in the lowest slice
      logic                            zs;
   } stim_row_type;

   localparam logic [HYP_LIMIT-1:0][VAL_W-1:0] ALL_ZERO = '0;
   localparam logic [HYP_LIMIT-1:0][VAL_W-1:0] HYP1_ONE = {17'd0, 17'd0, 17'd65536, 17'd0};

   // Runs under the reset configuration: eight detectors, four hypotheses.
   localparam int NUM_DIRECTED = 20;
   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      '{OP_COMBINE, 3'd0, 2'd0, 17'd0,      1'b1, ALL_ZERO, 1'b1},
      '{OP_SPARE,   3'd7, 2'd3, 17'd131071, 1'b0, ALL_ZERO, 1'b0},
      '{OP_STORE,   3'd0, 2'd1, 17'd131071, 1'b0, ALL_ZERO, 1'b0},
      '{OP_STORE,   3'd1, 2'd1, 17'd65536,  1'b0, ALL_ZERO, 1'b0},
      '{OP_STORE,   3'd2, 2'd1, 17'd65536,  1'b0, ALL_ZERO, 1'b0},
      '{OP_STORE,   3'd3, 2'd1, 17'd65536,  1'b0, ALL_ZERO, 1'b0},
      '{OP_STORE,   3'd4, 2'd1, 17'd65536,  1'b0, ALL_ZERO, 1'b0},
      '{OP_STORE,   3'd5, 2'd1, 17'd65536,  1'b0, ALL_ZERO, 1'b0},
      '{OP_STORE,   3'd6, 2'd1, 17'd65536,  1'b0, ALL_ZERO, 1'b0},
      '{OP_STORE,   3'd7, 2'd1, 17'd65536,  1'b0, ALL_ZERO, 1'b0},
      '{OP_COMBINE, 3'd0, 2'd0, 17'd0,      1'b1, HYP1_ONE, 1'b0},
      '{OP_STORE,   3'd7, 2'd3, 17'd131071, 1'b0, ALL_ZERO, 1'b0},
      '{OP_STORE,   3'd3, 2'd1, 17'd0,      1'b0, ALL_ZERO, 1'b0},
      '{OP_COMBINE, 3'd0, 2'd0, 17'd0,      1'b1, ALL_ZERO, 1'b1},
      '{OP_STORE,   3'd3, 2'd1, 17'd1,      1'b0, ALL_ZERO, 1'b0},
      '{OP_STORE,   3'd0, 2'd0, 17'd32768,  1'b0, ALL_ZERO, 1'b0},
      '{OP_COMBINE, 3'd0, 2'd0, 17'd0,      1'b0, ALL_ZERO, 1'b0},
      '{OP_CLEAR,   3'd5, 2'd2, 17'd98304,  1'b0, ALL_ZERO, 1'b0},
      '{OP_COMBINE, 3'd0, 2'd0, 17'd0,      1'b1, ALL_ZERO, 1'b1},
      '{OP_STORE,   3'd5, 2'd2, 17'd98304,  1'b0, ALL_ZERO, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = OP_STORE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_NUM_DET;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state
   logic [VAL_W-1:0]      lik_tbl [MAX_DETECTORS][MAX_HYPOTHESES];
   logic [ND_W-1:0]       cfg_nd;
   logic [NP_W-1:0]       cfg_np;
   logic [VAL_W-1:0]      cfg_prior [NUM_PRIORS];
   logic [CSR_DATA_W-1:0] csr_value [NUM_REGS];
   posterior_type         posterior_q [$];

   int   mismatches = 0;
   int   quiet_cycles = 0;
   int   snd_idle_pct = 0;
   int   rcv_idle_pct = 0;
   logic hold_start = 1'b0;
   logic rsp_hold = 1'b0;

   bayes_likelihood_combiner i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] cap_unity(input logic [63:0] v);
      return (v > UNITY) ? UNITY : v;
   endfunction

   function automatic int active_dets();
      return (cfg_nd > MAX_DETECTORS) ? MAX_DETECTORS : int'(cfg_nd);
   endfunction

   function automatic int active_hyps();
      return (cfg_np > HYP_LIMIT) ? HYP_LIMIT : int'(cfg_np);
   endfunction

   // Advance the predictor by one accepted item and queue the posteriors it causes.
   function automatic void predict_item(input logic [OP_W-1:0] op, input logic [DET_W-1:0] det,
                                        input logic [HYP_W-1:0] hyp, input logic [VAL_W-1:0] lik);
      logic [63:0] prod [HYP_LIMIT];
      logic [63:0] wgt [HYP_LIMIT];
      logic [63:0] acc;
      logic [63:0] total;
      logic [63:0] post;
      int          nd;
      int          np;
      nd = active_dets();
      np = active_hyps();
      total = '0;
      case (op)
         OP_STORE: lik_tbl[det][hyp] = VAL_W'(cap_unity(64'(lik)));
         OP_CLEAR: begin
            for (int d = 0; d < MAX_DETECTORS; d++)
               for (int h = 0; h < MAX_HYPOTHESES; h++)
                  lik_tbl[d][h] = '0;
         end
         OP_COMBINE: begin
            for (int p = 0; p < np; p++) begin
               acc = UNITY;
               // truncate after every multiply, as the block does
               for (int d = 0; d < nd; d++)
                  acc = (acc * 64'(lik_tbl[d][p])) >> FRAC_BITS;
               prod[p] = acc;
               wgt[p]  = cap_unity(64'(cfg_prior[p])) * acc;
               total   = total + wgt[p];
            end
            for (int p = 0; p < np; p++) begin
               post = (total == 0) ? prod[p] : cap_unity((wgt[p] << FRAC_BITS) / total);
               posterior_q.push_back('{HYP_W'(p), VAL_W'(post), total == 0, p == np - 1});
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] rand_lik();
      case ($urandom_range(9))
         0:       return '0;
         1:       return VAL_W'(UNITY);
         2:       return VAL_W'($urandom_range(131071));
         default: return VAL_W'($urandom_range(65536, 30000));
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] rand_prior();
      case ($urandom_range(7))
         0:       return '0;
         1:       return VAL_W'(UNITY);
         2:       return VAL_W'($urandom_range(131071));
         default: return VAL_W'($urandom_range(65536));
      endcase
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic offer_item(input logic [OP_W-1:0] op, input logic [DET_W-1:0] det,
                             input logic [HYP_W-1:0] hyp, input logic [VAL_W-1:0] lik);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, lik, hyp, det};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic issue_item(input logic [OP_W-1:0] op, input logic [DET_W-1:0] det,
                             input logic [HYP_W-1:0] hyp, input logic [VAL_W-1:0] lik);
      offer_item(op, det, hyp, lik);
      predict_item(op, det, hyp, lik);
   endtask

   // Drop valid, wait for every posterior, then let any result-free work finish.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (posterior_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings();
      csr_reg_type r;
      r = REG_NUM_DET;
      repeat (NUM_REGS) begin
         csr_wen   <= 1'b1;
         csr_index <= r;
         csr_wdata <= csr_value[r];
         case (r)
            REG_NUM_DET:  cfg_nd = csr_value[r][ND_W-1:0];
            REG_NUM_PART: cfg_np = csr_value[r][NP_W-1:0];
            default:      cfg_prior[int'(r) - int'(REG_PRIOR_0)] = csr_value[r];
         endcase
         @(posedge clock);
         r = r.next();
      end
      csr_wen <= 1'b0;
   endtask

   task automatic choose_settings(input int s);
      int nd;
      int np;
      int junk;
      nd = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(4, 1);
      np = ($urandom_range(5) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
      case (s)
         0: begin nd = 0;  np = 7; end   // empty product, hypothesis count saturates
         1: begin nd = 15; np = 1; end   // detector count saturates
         2: begin nd = 1;  np = 0; end   // combine yields nothing
         3: begin nd = 8;  np = 4; end
         default: ;
      endcase
      // upper write-data bits of the count registers carry noise half the time
      junk = $urandom_range(1) ? int'($urandom()) : 0;
      csr_value[REG_NUM_DET]  = CSR_DATA_W'(junk << ND_W) | CSR_DATA_W'(nd);
      junk = $urandom_range(1) ? int'($urandom()) : 0;
      csr_value[REG_NUM_PART] = CSR_DATA_W'(junk << NP_W) | CSR_DATA_W'(np);
      for (int p = 0; p < NUM_PRIORS; p++) begin
         case (s)
            4:       csr_value[int'(REG_PRIOR_0) + p] = '0;      // zero weighted sum
            5:       csr_value[int'(REG_PRIOR_0) + p] = '1;      // priors above 1.0
            6:       csr_value[int'(REG_PRIOR_0) + p] = CSR_DATA_W'(UNITY);
            default: csr_value[int'(REG_PRIOR_0) + p] = rand_prior();
         endcase
      end
   endtask

   // Mostly complete likelihood sets followed by a combine, the rest loose noise.
   task automatic feed_random(input int budget);
      int sent;
      int nde;
      int npe;
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(99)) inside
            [0:69]: begin
               nde = active_dets();
               npe = active_hyps();
               if (nde == 0) nde = $urandom_range(2, 1);
               if (npe == 0) npe = $urandom_range(4, 1);
               for (int h = 0; h < npe; h++)
                  for (int d = 0; d < nde; d++) begin
                     if ($urandom_range(19) == 0)
                        issue_item(OP_SPARE, DET_W'($urandom()), HYP_W'($urandom()), rand_lik());
                     // now and then leave an entry stale
                     if ($urandom_range(15) != 0) begin
                        issue_item(OP_STORE, DET_W'(d), HYP_W'(h), rand_lik());
                        sent++;
                     end
                  end
               issue_item(OP_COMBINE, DET_W'($urandom()), HYP_W'($urandom()), rand_lik());
               sent++;
            end
            [70:81]: begin
               issue_item(OP_STORE, DET_W'($urandom()), HYP_W'($urandom()), rand_lik());
               sent++;
            end
            [82:87]: begin
               issue_item(OP_CLEAR, DET_W'($urandom()), HYP_W'($urandom()), rand_lik());
               sent++;
            end
            [88:93]: issue_item(OP_SPARE, DET_W'($urandom()), HYP_W'($urandom()), rand_lik());
            default: begin
               issue_item(OP_COMBINE, DET_W'($urandom()), HYP_W'($urandom()), rand_lik());
               sent++;
            end
         endcase
      end
   endtask

   // Receiver: random stalls, one long hold-off, compare of all fields at once.
   always @(posedge clock) begin
      posterior_type want;
      posterior_type got;
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= rcv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[HYP_W-1:0], rsp_tdata[HYP_W +: VAL_W], rsp_tuser[0], rsp_tlast};
         if (posterior_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected posterior hyp=%0d post=%0d zs=%0d last=%0d",
                        $realtime, got.hyp, got.post, got.zs, got.last);
         end else begin
            want = posterior_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: posterior mismatch: expected hyp=%0d post=%0d zs=%0d last=%0d",
                           $realtime, want.hyp, want.post, want.zs, want.last);
                  $display("%0t: posterior mismatch: got      hyp=%0d post=%0d zs=%0d last=%0d",
                           $realtime, got.hyp, got.post, got.zs, got.last);
               end
            end
         end
      end
   end

   initial begin
      wait (hold_start);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int np;
      for (int d = 0; d < MAX_DETECTORS; d++)
         for (int h = 0; h < MAX_HYPOTHESES; h++)
            lik_tbl[d][h] = '0;
      cfg_nd = ND_W'(MAX_DETECTORS);
      cfg_np = NP_W'(HYP_LIMIT);
      for (int p = 0; p < NUM_PRIORS; p++)
         cfg_prior[p] = VAL_W'(16384);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      snd_idle_pct = 6;
      rcv_idle_pct = 55;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         offer_item(DIRECTED[i].op, DIRECTED[i].det, DIRECTED[i].hyp, DIRECTED[i].lik);
         if (DIRECTED[i].known) begin
            np = active_hyps();
            for (int p = 0; p < np; p++)
               posterior_q.push_back('{HYP_W'(p), DIRECTED[i].post[p], DIRECTED[i].zs,
                                       p == np - 1});
         end else begin
            predict_item(DIRECTED[i].op, DIRECTED[i].det, DIRECTED[i].hyp, DIRECTED[i].lik);
         end
      end

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         wait_quiet();
         case (s / SETTINGS_PER_PHASE)
            0:       begin snd_idle_pct = 6;  rcv_idle_pct = 55; end
            1:       begin snd_idle_pct = 55; rcv_idle_pct = 6;  end
            default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
         endcase
         choose_settings(s);
         write_settings();
         if (s == HOLD_SETTING) hold_start = 1'b1;
         feed_random(ITEMS_PER_SETTING);
      end

      wait_quiet();
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
